@@ rtl/xor_popcount_pair_filter_macros.svh @@
// Assertion macros shared by the pair filter RTL.
`ifndef XOR_POPCOUNT_PAIR_FILTER_MACROS_SVH
`define XOR_POPCOUNT_PAIR_FILTER_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define XPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define XPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/xpf_pkg.sv @@
// Types, constants and helpers of the sketch pair filter.
package xpf_pkg;

  localparam int unsigned XPF_STORE_DEPTH = 64;
  localparam int unsigned SKETCH_W        = 128;
  localparam int unsigned HALF_W          = 64;
  localparam int unsigned IDX_W           = 6;
  localparam int unsigned DIST_W          = 8;
  localparam int unsigned PC_W            = 7;
  localparam int unsigned CFG_W           = 7;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned INDEX_LIMIT     = 64;
  localparam int unsigned RES_FIFO_DEPTH  = 8;

  localparam logic [CFG_W-1:0]  THR_RESET   = 7'd47;
  localparam logic [DIST_W-1:0] SKETCH_BITS = 8'd128;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QREAD,
    ST_QLOAD,
    ST_SCAN,
    ST_DRAIN
  } xpf_state_e;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic              found;
    logic              last;
  } xpf_res_t;

  // distance pipeline status towards the controller
  typedef struct packed {
    logic              s0_vld;
    logic              s1_vld;
    logic              s2_vld;
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
  } xpf_dist_t;

  // popcount of 64 bits: per-byte counts, then a sum over eight bytes
  function automatic logic [PC_W-1:0] popcnt64(input logic [HALF_W-1:0] v);
    logic [7:0][3:0] byte_cnt;
    logic [PC_W-1:0] sum;
    byte_cnt = '0;
    sum      = '0;
    for (int b = 0; b < 8; b++) begin
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[8*b+k]);
      end
    end
    for (int b = 0; b < 8; b++) begin
      sum = sum + PC_W'(byte_cnt[b]);
    end
    return sum;
  endfunction

endpackage

@@ rtl/xpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module xpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/xpf_fifo.sv @@
// Result queue between the search engine and the output channel.
module xpf_fifo import xpf_pkg::*; #(
  parameter int unsigned DEPTH = RES_FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  xpf_res_t                   push_data_i,
  input  logic                       pop_i,
  output xpf_res_t                   head_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  xpf_res_t          slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;

endmodule

@@ rtl/xpf_dist.sv @@
// Distance pipeline: XOR, split popcount, sum and threshold test.
module xpf_dist import xpf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                issue_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  logic [SKETCH_W-1:0] query_i,
  input  logic [SKETCH_W-1:0] rdata_i,
  input  logic [CFG_W-1:0]    thr_i,
  output xpf_dist_t           stat_o
);

  logic                s0_vld_q, s1_vld_q, s2_vld_q;
  logic [IDX_W-1:0]    s0_idx_q, s1_idx_q, s2_idx_q;
  logic [PC_W-1:0]     pc_lo_q, pc_hi_q;
  logic [SKETCH_W-1:0] diff;
  logic [DIST_W-1:0]   sum;
  logic [DIST_W-1:0]   far_bound;
  logic [DIST_W-1:0]   s2_dist_q;
  logic                s2_hit_q;
  logic                hit;

  // s0 lines up with the RAM's registered read
  assign diff      = query_i ^ rdata_i;
  assign sum       = DIST_W'(pc_lo_q) + DIST_W'(pc_hi_q);
  assign far_bound = SKETCH_BITS - DIST_W'(thr_i);
  assign hit       = (sum < DIST_W'(thr_i)) || (sum > far_bound);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= issue_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_idx_q  <= idx_i;
    s1_idx_q  <= s0_idx_q;
    pc_lo_q   <= popcnt64(diff[HALF_W-1:0]);
    pc_hi_q   <= popcnt64(diff[SKETCH_W-1:HALF_W]);
    s2_idx_q  <= s1_idx_q;
    s2_dist_q <= sum;
    s2_hit_q  <= hit;
  end

  assign stat_o = '{
    s0_vld:   s0_vld_q,
    s1_vld:   s1_vld_q,
    s2_vld:   s2_vld_q,
    hit:      s2_hit_q,
    idx:      s2_idx_q,
    distance: s2_dist_q
  };

endmodule

@@ rtl/xor_popcount_pair_filter.sv @@
// Top level of the 128-bit sketch store with Hamming-distance pair filter.
//
// A write beat stores a 128-bit sketch in the sketch RAM and gives no
// result; writes may follow each other every cycle while no search holds
// the input. A search beat for query slot i reads slot i, then streams
// slots j from the active count minus one down to i+1 through the single
// RAM read port, one slot per cycle while the result buffer has room,
// into a three-stage distance pipeline. Each slot whose distance is
// below the threshold, or above 128 minus it, gives one result beat; the
// final beat carries last, and a search that matches nothing, or names a
// slot outside the active count, gives one beat with found low. A search
// holds the input stalled until its final beat is queued. Results queue
// in an eight-beat buffer, and the scan pauses while that buffer lacks
// room for the beats still in the pipeline. The store is not cleared: a
// slot must be written before a search reads it.
`include "xor_popcount_pair_filter_macros.svh"

module xor_popcount_pair_filter import xpf_pkg::*; #(
  parameter int unsigned STORE_DEPTH = XPF_STORE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_cmd_i,
  input  logic [IDX_W-1:0]     in_entry_index_i,
  input  logic [HALF_W-1:0]    in_sketch_low_i,
  input  logic [HALF_W-1:0]    in_sketch_high_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     out_match_index_o,
  output logic [DIST_W-1:0]    out_hamming_distance_o,
  output logic                 out_found_o,
  output logic                 out_last_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // only slots an entry index can reach are stored
  localparam int unsigned LIVE_DEPTH = (STORE_DEPTH < INDEX_LIMIT) ? STORE_DEPTH : INDEX_LIMIT;
  localparam int unsigned AW         = $clog2(LIVE_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RES_FIFO_DEPTH + 1);
  localparam int unsigned SUM_W      = CNT_W + 1;
  localparam logic [CFG_W-1:0] LIVE_CNT = CFG_W'(LIVE_DEPTH);
  localparam logic [CNT_W-1:0] FIFO_FULL = CNT_W'(RES_FIFO_DEPTH);

  xpf_state_e          state_q, state_d;
  logic [IDX_W-1:0]    q_idx_q, q_idx_d;
  logic [IDX_W-1:0]    j_q, j_d;
  logic [CFG_W-1:0]    thr_q, act_q;
  logic [SKETCH_W-1:0] query_q;
  xpf_res_t            held_q;
  logic                held_vld_q;

  logic                in_acc, search_acc, ram_we;
  logic [CFG_W-1:0]    cnt_eff;
  logic                ram_re, issue, query_ld, final_push;
  logic [IDX_W-1:0]    raddr_idx;
  logic [SKETCH_W-1:0] ram_rdata;
  xpf_dist_t           dstat;
  logic                pipe_empty, room;
  logic [1:0]          inflight;
  logic [SUM_W-1:0]    credit_sum;
  logic [CNT_W-1:0]    fifo_cnt;
  logic                res_push;
  xpf_res_t            res_data, head;
  logic                hit_push;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign search_acc = in_acc && (in_cmd_i == CMD_SEARCH);
  // writes past the store are dropped
  assign ram_we     = in_acc && (in_cmd_i == CMD_WRITE) &&
                      ({1'b0, in_entry_index_i} < LIVE_CNT);
  assign cnt_eff    = (act_q > LIVE_CNT) ? LIVE_CNT : act_q;

  // searches hold off new beats; writes never meet a scan
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      act_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: thr_q <= cfg_data_i;
        CFG_ACTIVE:    act_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------- store
  xpf_ram #(
    .WIDTH (SKETCH_W),
    .DEPTH (LIVE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_entry_index_i[AW-1:0]),
    .wdata_i ({in_sketch_high_i, in_sketch_low_i}),
    .re_i    (ram_re),
    .raddr_i (raddr_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- distance
  xpf_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .idx_i   (j_q),
    .query_i (query_q),
    .rdata_i (ram_rdata),
    .thr_i   (thr_q),
    .stat_o  (dstat)
  );

  assign pipe_empty = !dstat.s0_vld && !dstat.s1_vld && !dstat.s2_vld;
  assign inflight   = {1'b0, dstat.s0_vld} + {1'b0, dstat.s1_vld} + {1'b0, dstat.s2_vld};
  // every beat in flight may still push one result
  assign credit_sum = SUM_W'(fifo_cnt) + SUM_W'(inflight);
  assign room       = credit_sum < SUM_W'(FIFO_FULL);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d    = state_q;
    q_idx_d    = q_idx_q;
    j_d        = j_q;
    ram_re     = 1'b0;
    raddr_idx  = j_q;
    issue      = 1'b0;
    query_ld   = 1'b0;
    final_push = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (search_acc) begin
          q_idx_d = in_entry_index_i;
          j_d     = IDX_W'(cnt_eff - CFG_W'(1));
          // query outside the active count: straight to the empty beat
          state_d = ({1'b0, in_entry_index_i} >= cnt_eff) ? ST_DRAIN : ST_QREAD;
        end
      end
      ST_QREAD: begin
        ram_re    = 1'b1;
        raddr_idx = q_idx_q;
        state_d   = ST_QLOAD;
      end
      ST_QLOAD: begin
        query_ld = 1'b1;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_q > q_idx_q) begin
          if (room) begin
            ram_re = 1'b1;
            issue  = 1'b1;
            j_d    = j_q - IDX_W'(1);
          end
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && (fifo_cnt != FIFO_FULL)) begin
          final_push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_idx_q <= q_idx_d;
    j_q     <= j_d;
    if (query_ld) begin
      query_q <= ram_rdata;
    end
  end

  // ---------------------------------------------------------------- results
  // one match is held back so the final one can carry last
  assign hit_push = dstat.s2_vld && dstat.hit && held_vld_q;

  always_comb begin
    res_push = 1'b0;
    res_data = '{idx: '0, distance: '0, found: 1'b0, last: 1'b1};
    if (hit_push) begin
      res_push      = 1'b1;
      res_data      = held_q;
      res_data.last = 1'b0;
    end else if (final_push) begin
      res_push = 1'b1;
      if (held_vld_q) begin
        res_data      = held_q;
        res_data.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_vld_q <= 1'b0;
    end else if (search_acc) begin
      held_vld_q <= 1'b0;
    end else if (dstat.s2_vld && dstat.hit) begin
      held_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dstat.s2_vld && dstat.hit) begin
      held_q <= '{idx: dstat.idx, distance: dstat.distance, found: 1'b1, last: 1'b0};
    end
  end

  xpf_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_data),
    .pop_i       (!out_stall_i),
    .head_o      (head),
    .valid_o     (out_valid_o),
    .count_o     (fifo_cnt)
  );

  assign out_match_index_o      = head.idx;
  assign out_hamming_distance_o = head.distance;
  assign out_found_o            = head.found;
  assign out_last_o             = head.last;

  // ---------------------------------------------------------------- checks
  `XPF_ASSERT_NOW(a_no_overflow, res_push, fifo_cnt != FIFO_FULL, "result queue overflow")
  `XPF_ASSERT_NOW(a_write_idle, ram_we, state_q == ST_IDLE, "store written during a search")
  `XPF_ASSERT_NOW(a_idle_empty, state_q == ST_IDLE, pipe_empty, "pipeline busy while idle")
  `XPF_ASSERT_NEXT(a_last_ends, res_push && res_data.last, state_q == ST_IDLE, "last beat mid-search")
  `XPF_ASSERT_NOW(a_scan_range, issue, j_q > q_idx_q, "scan read at or below query slot")

endmodule
